/* hdl/sequential_array_list_macros.svh */
// Assertion macros for the checker file of the array list block.
`ifndef SEQUENTIAL_ARRAY_LIST_MACROS_SVH
`define SEQUENTIAL_ARRAY_LIST_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that the consequence holds in the cycle after the trigger.
`define SAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/sal_pkg.sv */
// Shared constants, types and codes of the array list block.
package sal_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int OUT_W    = 7;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WIDE_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [DATA_W-1:0]   data_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [WIDE_W-1:0]   wide_t;
  typedef logic [CAPACITY-1:0] vec_t;
  typedef logic [OUT_W-1:0]    out_t;

  localparam out_t FOUND_NONE = '1;

  typedef enum logic [2:0] {
    CMD_APPEND    = 3'd0,
    CMD_WRITE_AT  = 3'd1,
    CMD_REMOVE_AT = 3'd2,
    CMD_REMOVE_VL = 3'd3,
    CMD_READ_AT   = 3'd4,
    CMD_FIND      = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_BAD_POS   = 2'd1,
    STS_FULL      = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_MATCH = 3'b010,
    ST_APPLY = 3'b100
  } state_e;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic  match_en;
    logic  wr_en;
    logic  shift_pos;
    logic  shift_mask;
    data_t key;
    idx_t  pos;
    cnt_t  count;
  } cell_ctl_t;

endpackage

/* hdl/sequential_array_list.sv */
// Top level of the array list: command sequencer over a chain of slot cells.
//
// Usage: drive cmd_i, position_i and value_i and raise start while busy is low;
// the command transfers at that clock edge. busy then stays high through the
// compare state, in which every cell compares its word with value_i, and the
// apply state, in which the match vector is encoded, the cells write or shift
// down, and the count moves. The result (status_o, read_value_o, found_index_o,
// item_total_o) is shown for exactly one cycle with done_o high, from registers
// loaded at the end of the apply state. busy is already low in that result
// cycle, so a new command can transfer at the edge that ends it, but not before.
// The receiver has no stall; a result is taken in the cycle it is shown.
// Reset clears the count, the sequencer and the strobe; slot words are not
// cleared, and only slots below the count are ever read.
module sequential_array_list (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         cmd_i,
  input  logic signed [7:0]  position_i,
  input  logic signed [31:0] value_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] read_value_o,
  output logic signed [6:0]  found_index_o,
  output logic [6:0]         item_total_o
);

  sal_pkg::state_e    state_q, state_d;
  sal_pkg::cnt_t      count_q, count_d;
  logic [2:0]         cmd_q;
  logic [sal_pkg::POS_W-1:0] pos_q;
  sal_pkg::data_t     val_q;

  logic               done_q;
  sal_pkg::status_e   status_q, status_d;
  sal_pkg::data_t     rd_q, rd_d;
  sal_pkg::out_t      found_q, found_d;

  sal_pkg::cell_ctl_t ctl;
  sal_pkg::data_t     chain [sal_pkg::CAPACITY];
  sal_pkg::data_t     rd_cell [sal_pkg::CAPACITY];
  sal_pkg::vec_t      match;
  sal_pkg::vec_t      tail;
  sal_pkg::idx_t      first_idx;
  logic               any_hit;
  sal_pkg::data_t     rd_or;

  logic               accept;
  logic               pos_neg;
  sal_pkg::wide_t     pos_w;
  sal_pkg::wide_t     cnt_w;
  sal_pkg::wide_t     cap_w;
  logic               apply;

  assign accept = start && !busy;
  assign busy   = (state_q != sal_pkg::ST_IDLE);
  assign apply  = (state_q == sal_pkg::ST_APPLY);

  // Capture the command on transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
  end

  // Step the sequencer: idle, compare, apply
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sal_pkg::ST_IDLE:  if (accept) state_d = sal_pkg::ST_MATCH;
      sal_pkg::ST_MATCH: state_d = sal_pkg::ST_APPLY;
      sal_pkg::ST_APPLY: state_d = sal_pkg::ST_IDLE;
      default:           state_d = sal_pkg::ST_IDLE;
    endcase
  end

  // Widen position, count and capacity to one compare width
  assign pos_neg = pos_q[sal_pkg::POS_W-1];
  assign pos_w   = sal_pkg::wide_t'(pos_q[sal_pkg::POS_W-2:0]);
  assign cnt_w   = sal_pkg::wide_t'(count_q);
  assign cap_w   = sal_pkg::wide_t'(sal_pkg::CAPACITY);

  // Gather the read word from the selected cell
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < sal_pkg::CAPACITY; i++) begin
      rd_or = rd_or | rd_cell[i];
    end
  end

  // Decide the command outcome and drive the cells
  always_comb begin
    ctl            = '0;
    ctl.key        = val_q;
    ctl.count      = count_q;
    ctl.pos        = pos_w[sal_pkg::IDX_W-1:0];
    ctl.match_en   = (state_q == sal_pkg::ST_MATCH);
    count_d        = count_q;
    status_d       = sal_pkg::STS_OK;
    rd_d           = '0;
    found_d        = sal_pkg::FOUND_NONE;
    unique case (sal_pkg::cmd_e'(cmd_q))
      sal_pkg::CMD_APPEND: begin
        ctl.pos = count_q[sal_pkg::IDX_W-1:0];
        if (cnt_w >= cap_w) begin
          status_d = sal_pkg::STS_FULL;
        end else begin
          ctl.wr_en = apply;
          count_d   = count_q + sal_pkg::cnt_t'(1);
        end
      end
      sal_pkg::CMD_WRITE_AT: begin
        if (pos_neg || (pos_w >= cap_w) || (pos_w > cnt_w)) begin
          status_d = sal_pkg::STS_BAD_POS;
        end else begin
          ctl.wr_en = apply;
          if (pos_w == cnt_w) begin
            count_d = count_q + sal_pkg::cnt_t'(1);
          end
        end
      end
      sal_pkg::CMD_REMOVE_AT: begin
        if (pos_neg || (pos_w >= cnt_w)) begin
          status_d = sal_pkg::STS_BAD_POS;
        end else begin
          ctl.shift_pos = apply;
          count_d       = count_q - sal_pkg::cnt_t'(1);
        end
      end
      sal_pkg::CMD_REMOVE_VL: begin
        if (any_hit) begin
          ctl.shift_mask = apply;
          count_d        = count_q - sal_pkg::cnt_t'(1);
        end else begin
          status_d = sal_pkg::STS_NOT_FOUND;
        end
      end
      sal_pkg::CMD_READ_AT: begin
        if (pos_neg || (pos_w >= cnt_w)) begin
          status_d = sal_pkg::STS_BAD_POS;
        end else begin
          rd_d = rd_or;
        end
      end
      sal_pkg::CMD_FIND: begin
        if (any_hit) begin
          found_d = sal_pkg::out_t'(first_idx);
        end else begin
          status_d = sal_pkg::STS_NOT_FOUND;
        end
      end
      default: begin
        status_d = sal_pkg::STS_BAD_POS;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sal_pkg::ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= apply;
      if (apply) begin
        count_q <= count_d;
      end
    end
  end

  // Register the result for its one-cycle strobe
  always_ff @(posedge clk_i) begin
    if (apply) begin
      status_q <= status_d;
      rd_q     <= rd_d;
      found_q  <= found_d;
    end
  end

  // Build the cell chain, each cell below the top fed by its upper neighbor
  for (genvar g = 0; g < sal_pkg::CAPACITY; g++) begin : g_cell
    sal_pkg::data_t next;
    if (g == sal_pkg::CAPACITY - 1) begin : g_top
      assign next = '0;
    end else begin : g_mid
      assign next = chain[g+1];
    end
    sal_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (sal_pkg::idx_t'(g)),
      .ctl_i   (ctl),
      .tail_i  (tail[g]),
      .next_i  (next),
      .data_o  (chain[g]),
      .match_o (match[g]),
      .rd_o    (rd_cell[g])
    );
  end

  sal_enc u_enc (
    .match_i (match),
    .any_o   (any_hit),
    .first_o (first_idx),
    .tail_o  (tail)
  );

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign read_value_o  = rd_q;
  assign found_index_o = found_q;
  assign item_total_o  = cnt_w[sal_pkg::OUT_W-1:0];

endmodule

/* hdl/sal_cell.sv */
// One list slot: holds a word, compares it, and shifts from its upper neighbor.
module sal_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sal_pkg::idx_t      idx_i,
  input  sal_pkg::cell_ctl_t ctl_i,
  input  logic               tail_i,
  input  sal_pkg::data_t     next_i,
  output sal_pkg::data_t     data_o,
  output logic               match_o,
  output sal_pkg::data_t     rd_o
);

  sal_pkg::data_t data_q;
  logic           match_q;
  logic           sel;
  logic           live;
  logic           shift;

  // Decode this slot against the broadcast position and count
  assign sel   = (idx_i == ctl_i.pos);
  assign live  = (sal_pkg::cnt_t'(idx_i) < ctl_i.count);
  assign shift = (ctl_i.shift_pos && (idx_i >= ctl_i.pos)) ||
                 (ctl_i.shift_mask && tail_i);

  // Take the neighbor's word on a shift, or the key on a write
  always_ff @(posedge clk_i) begin
    if (shift) begin
      data_q <= next_i;
    end else if (ctl_i.wr_en && sel) begin
      data_q <= ctl_i.key;
    end
  end

  // Latch the key compare for held slots only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctl_i.match_en) begin
      match_q <= live && (data_q == ctl_i.key);
    end
  end

  assign data_o  = data_q;
  assign match_o = match_q;
  assign rd_o    = sel ? data_q : '0;

endmodule

/* hdl/sal_enc.sv */
// Match encoder: first matching index and the tail at and above the last match.
module sal_enc (
  input  sal_pkg::vec_t match_i,
  output logic          any_o,
  output sal_pkg::idx_t first_o,
  output sal_pkg::vec_t tail_o
);

  localparam sal_pkg::vec_t ONE = sal_pkg::vec_t'(1);

  sal_pkg::vec_t lone;
  sal_pkg::vec_t rev;
  sal_pkg::vec_t rev_low;

  assign any_o = |match_i;

  // Isolate the lowest set bit and turn it into an index
  assign lone = match_i & (~match_i + ONE);

  always_comb begin
    first_o = '0;
    for (int i = 0; i < sal_pkg::CAPACITY; i++) begin
      if (lone[i]) begin
        first_o = first_o | sal_pkg::idx_t'(i);
      end
    end
  end

  // Mark slots at or above the highest set bit by working on the reversed vector
  always_comb begin
    for (int i = 0; i < sal_pkg::CAPACITY; i++) begin
      rev[i] = match_i[sal_pkg::CAPACITY-1-i];
    end
  end

  assign rev_low = rev ^ (rev - ONE);

  always_comb begin
    for (int i = 0; i < sal_pkg::CAPACITY; i++) begin
      tail_o[i] = rev_low[sal_pkg::CAPACITY-1-i];
    end
  end

endmodule

/* hdl/sal_checker.sv */
// Port-level checker for the array list, bound to the top level.
`include "sequential_array_list_macros.svh"

module sal_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input logic [1:0]         status_o,
  input logic signed [6:0]  found_index_o
);

  // A transfer keeps the block busy and is later followed by its result strobe
  `SAL_ASSERT_NEXT(a_busy_after_xfer, start && !busy, busy, "busy low after transfer")
  `SAL_ASSERT(a_result_latency, (start && !busy) |-> ##3 done_o, "result not on time")
  // The result strobe falls in an idle cycle and lasts one cycle
  `SAL_ASSERT(a_done_idle, done_o |-> (!busy && !$past(done_o)), "strobe while busy")
  // A found index only comes with an ok status
  `SAL_ASSERT(a_found_ok, (done_o && (found_index_o != sal_pkg::FOUND_NONE)) |->
    (status_o == sal_pkg::STS_OK), "index with failing status")

endmodule

bind sequential_array_list sal_checker u_sal_checker (.*);
